@@ hw/rtl/etfp_pkg.sv @@
// Package for the telemetry frame parser: frame geometry, register indexes,
// status codes and the verdict word passed from the front end to the back end.
// No dependencies.
package etfp_pkg;

   localparam int FRAME_LENGTH = 32;
   localparam int POS_W        = $clog2(FRAME_LENGTH);
   localparam int HELD_FIRST   = 9;
   localparam int HELD_COUNT   = 15;
   localparam int TELE_W       = 8 * HELD_COUNT;
   localparam int TAG_FIRST    = 1;
   localparam int TAG_BYTES    = 4;
   localparam int RSP_DATA_W   = 112;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0]  SYNC_RESET    = 8'hFE;
   localparam logic [31:0] TAG_RESET     = 32'h3003_0001;
   localparam logic [15:0] CRC_START     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_BYTE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_TAG = 1'd1;

   typedef enum logic [1:0] {
      STATUS_VALID   = 2'd0,
      STATUS_TAG_BAD = 2'd1,
      STATUS_CRC_BAD = 2'd2
   } status_type;

   // One finished frame: its status and its telemetry bytes 9..23, byte 9 lowest.
   typedef struct packed {
      status_type        status;
      logic [TELE_W-1:0] tele;
   } verdict_type;

endpackage

@@ hw/rtl/etfp_front.sv @@
// Front end of the telemetry frame parser: sync hunt, byte counting, CRC and
// capture of the tag, telemetry and checksum bytes. Depends on etfp_pkg.
module etfp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rx_valid,
   input  logic [7:0]           rx_byte,
   output logic                 rx_ready,
   input  logic [7:0]           sync_byte,
   input  logic [31:0]          frame_tag,
   input  logic                 q_full,
   output logic                 push,
   output etfp_pkg::verdict_type verdict
);
   import etfp_pkg::*;

   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_LENGTH - 1);
   localparam logic [POS_W-1:0] POS_SUM_LO  = POS_W'(FRAME_LENGTH - 2);
   localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(1);

   logic              in_frame_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [15:0]       crc_ff;
   logic [15:0]       crc_in;
   logic [31:0]       tag_ff;
   logic [7:0]        sum_lo_ff;
   logic [TELE_W-1:0] tele_ff;
   logic              last;
   logic              accept;
   logic [15:0]       sum;

   // Byte-wise reflected CRC-16 update, eight bit steps.
   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   assign last     = in_frame_ff && (pos_ff == POS_LAST);
   assign rx_ready = !(last && q_full);
   assign accept   = rx_valid && rx_ready;
   assign crc_in   = crc_add(in_frame_ff ? crc_ff : CRC_START, rx_byte);
   assign push     = accept && last;
   assign sum      = {rx_byte, sum_lo_ff};

   always_comb begin
      verdict.tele = tele_ff;
      if (tag_ff != frame_tag) begin
         verdict.status = STATUS_TAG_BAD;
      end else if (sum != crc_ff) begin
         verdict.status = STATUS_CRC_BAD;
      end else begin
         verdict.status = STATUS_VALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         crc_ff      <= CRC_START;
      end else if (accept) begin
         if (!in_frame_ff) begin
            if (rx_byte == sync_byte) begin
               in_frame_ff <= 1'b1;
               pos_ff      <= POS_FIRST;
               crc_ff      <= crc_in;
            end
         end else if (last) begin
            in_frame_ff <= 1'b0;
            pos_ff      <= '0;
            crc_ff      <= CRC_START;
         end else begin
            pos_ff <= pos_ff + POS_FIRST;
            if (pos_ff < POS_SUM_LO) begin
               crc_ff <= crc_in;
            end
         end
      end
   end

   // Capture lanes; each byte lane owns one frame position.
   always_ff @(posedge clock) begin
      if (accept && in_frame_ff) begin
         for (int i = 0; i < TAG_BYTES; i++) begin
            if (pos_ff == POS_W'(TAG_FIRST + i)) begin
               tag_ff[8*i +: 8] <= rx_byte;
            end
         end
         for (int i = 0; i < HELD_COUNT; i++) begin
            if (pos_ff == POS_W'(HELD_FIRST + i)) begin
               tele_ff[8*i +: 8] <= rx_byte;
            end
         end
         if (pos_ff == POS_SUM_LO) begin
            sum_lo_ff <= rx_byte;
         end
      end
   end

endmodule

@@ hw/rtl/etfp_queue.sv @@
// Short verdict queue between the front and back ends of the frame parser.
// Depends on etfp_pkg.
module etfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  etfp_pkg::verdict_type push_data,
   output logic                  full,
   output logic                  pop_valid,
   input  logic                  pop,
   output etfp_pkg::verdict_type pop_data
);
   import etfp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   verdict_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/etfp_back.sv @@
// Back end of the frame parser: held telemetry and the result register.
// Depends on etfp_pkg.
module etfp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  etfp_pkg::verdict_type q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output etfp_pkg::status_type  rsp_status,
   output logic [etfp_pkg::TELE_W-1:0] rsp_tele
);
   import etfp_pkg::*;

   logic              rsp_valid_ff;
   status_type        status_ff;
   logic [TELE_W-1:0] out_tele_ff;
   logic [TELE_W-1:0] held_ff;
   logic              load;

   assign load       = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop      = load;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_tele   = out_tele_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load && q_data.status == STATUS_VALID) begin
            held_ff <= q_data.tele;
         end
      end
   end

   // Bad frames repeat the last good telemetry.
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff   <= q_data.status;
         out_tele_ff <= (q_data.status == STATUS_VALID) ? q_data.tele : held_ff;
      end
   end

endmodule

@@ hw/rtl/esc_telemetry_frame_parser.sv @@
// Telemetry frame parser. Takes one received byte per req word, hunts for the
// sync byte, then collects a 32-byte frame (sync byte is byte 0) and checks it:
// bytes 1..4 little-endian against frame_tag, then CRC-16/MODBUS over bytes
// 0..29 against bytes 30..31 little-endian. After byte 31 one rsp word leaves,
// carrying a status (valid, tag mismatch, or CRC mismatch; tag is tested first)
// and the telemetry fields. A valid frame refreshes the held telemetry; a bad
// frame repeats the last valid values (zero after reset). A sync byte inside a
// frame is data: there is no mid-frame resync. The block takes one byte every
// clock; the CRC unit absorbs a whole byte per cycle. The result of a frame
// passes through a two-entry verdict queue and the output register, so req only
// stalls on the last byte of a frame while that queue is full. Registers: index
// 0 sync_byte (reset 0xFE), index 1 frame_tag (reset 0x30030001); write them
// only while the parser is idle.
// Depends on etfp_pkg, etfp_front, etfp_queue and etfp_back.
module esc_telemetry_frame_parser (
   input  logic        clock,
   input  logic        reset,
   // Input byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] throttle_in, [15:8] throttle_out, [23:16] direction,
   // [39:24] rpm_raw, [55:40] voltage_raw, [71:56] current_raw,
   // [87:72] controller_temp, [103:88] motor_temp, [111:104] bec_current
   output logic [etfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Register writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [etfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [etfp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import etfp_pkg::*;

   logic [7:0]        sync_byte_ff;
   logic [31:0]       frame_tag_ff;
   logic              q_full;
   logic              q_push;
   logic              q_valid;
   logic              q_pop;
   verdict_type       push_verdict;
   verdict_type       pop_verdict;
   status_type        rsp_status;
   logic [TELE_W-1:0] rsp_tele;

   // Registers accept a write every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff <= SYNC_RESET;
         frame_tag_ff <= TAG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_BYTE: sync_byte_ff <= csr_data[7:0];
            CSR_FRAME_TAG: frame_tag_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // Front end: hunt, count, CRC, capture; pushes one verdict per frame.
   etfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .rx_valid  (req_tvalid),
      .rx_byte   (req_tdata),
      .rx_ready  (req_tready),
      .sync_byte (sync_byte_ff),
      .frame_tag (frame_tag_ff),
      .q_full    (q_full),
      .push      (q_push),
      .verdict   (push_verdict)
   );

   // Decouple the front end from a stalled result side.
   etfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_verdict),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_data  (pop_verdict)
   );

   // Back end: hold good telemetry, drive the result register.
   etfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (pop_verdict),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_tele   (rsp_tele)
   );

   // Drop frame byte 12 (lane 3); the rest packs straight through.
   assign rsp_tdata = {rsp_tele[TELE_W-1:32], rsp_tele[23:0]};
   assign rsp_tuser = rsp_status;

   // A verdict is only pushed when the queue has room.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("verdict pushed into a full queue");

   // A verdict only comes from an accepted byte.
   a_push_on_accept : assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_tvalid && req_tready))
      else $error("verdict pushed without an accepted byte");

   // Status never carries the unused code.
   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("result carries an undefined status");

   // A popped verdict always lands in the output register next cycle.
   a_pop_loads : assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_tvalid)
      else $error("popped verdict did not reach the output");

endmodule

@@ bench/esc_telemetry_frame_parser_test.sv @@
// Self-checking bench for the telemetry frame parser: builds sync-led 32-byte
// frames, predicts each frame's status and held telemetry, checks every rsp word.
// Depends on etfp_pkg and esc_telemetry_frame_parser.
`timescale 1ns / 1ps

module esc_telemetry_frame_parser_test;
   import etfp_pkg::*;

   // Field slots of one result word: status first, then telemetry in port order.
   localparam int FIELD_COUNT = 10;
   typedef logic [FIELD_COUNT-1:0][15:0] telemetry_fields_type;

   // Shapes of frame that the stimulus builds.
   typedef enum int {FK_GOOD, FK_TAG_BAD, FK_CRC_BAD, FK_BOTH_BAD, FK_SHORT} frame_kind_type;
   // Content of the payload bytes 5..29.
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SYNC} fill_type;

   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;

   const string field_name [FIELD_COUNT] = '{"status", "throttle_in", "throttle_out",
      "direction", "rpm_raw", "voltage_raw", "current_raw", "controller_temp",
      "motor_temp", "bec_current"};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SYNC_BYTE;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   esc_telemetry_frame_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Parser state as the bench sees it; advanced on every accepted req word.
   logic [7:0]  sync_setting = SYNC_RESET;
   logic [31:0] tag_setting  = TAG_RESET;
   logic        frame_open   = 1'b0;
   int          byte_pos     = 0;
   logic [15:0] crc_acc      = CRC_START;
   logic [7:0]  frame_bytes [FRAME_LENGTH];
   logic [7:0]  held_bytes  [HELD_COUNT] = '{default: 8'h00};

   telemetry_fields_type frame_results [$];   // results still owed by the block
   logic [7:0]      byte_feed [$];       // bytes waiting for the driver
   int bytes_queued = 0;
   int bytes_taken  = 0;
   int error_count  = 0;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_armed = 1'b0;
   logic rsp_hold   = 1'b0;

   initial begin : clock_gen
      forever #4 clock = ~clock;
   end

   // Reflected CRC-16, one byte at a time (MODBUS flavour).
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int i = 0; i < 8; i++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      return c;
   endfunction

   // Advance the frame tracker by one received byte; queue the result at byte 31.
   task automatic absorb_byte(input logic [7:0] b);
      logic [31:0] tag_seen;
      logic [15:0] sum_seen;
      status_type  verdict;
      telemetry_fields_type want;
      if (!frame_open) begin
         // Anything but the sync byte is dropped while hunting.
         if (b == sync_setting) begin
            frame_open = 1'b1;
            frame_bytes[0] = b;
            crc_acc = crc16_step(CRC_START, b);
            byte_pos = 1;
         end
         return;
      end
      // Inside a frame every byte is data, the sync value included.
      frame_bytes[byte_pos] = b;
      if (byte_pos < FRAME_LENGTH - 2)
         crc_acc = crc16_step(crc_acc, b);
      if (byte_pos != FRAME_LENGTH - 1) begin
         byte_pos++;
         return;
      end
      frame_open = 1'b0;
      byte_pos = 0;
      tag_seen = {frame_bytes[4], frame_bytes[3], frame_bytes[2], frame_bytes[1]};
      sum_seen = {frame_bytes[FRAME_LENGTH-1], frame_bytes[FRAME_LENGTH-2]};
      // Tag is judged before the checksum, so a frame wrong in both reads as a tag fault.
      if (tag_seen != tag_setting)
         verdict = STATUS_TAG_BAD;
      else if (sum_seen != crc_acc)
         verdict = STATUS_CRC_BAD;
      else
         verdict = STATUS_VALID;
      if (verdict == STATUS_VALID) begin
         for (int i = 0; i < HELD_COUNT; i++)
            held_bytes[i] = frame_bytes[HELD_FIRST + i];
      end
      crc_acc = CRC_START;
      want = '0;
      want[0] = 16'(verdict);
      want[1] = {8'h00, held_bytes[0]};
      want[2] = {8'h00, held_bytes[1]};
      want[3] = {8'h00, held_bytes[2]};
      want[4] = {held_bytes[5], held_bytes[4]};
      want[5] = {held_bytes[7], held_bytes[6]};
      want[6] = {held_bytes[9], held_bytes[8]};
      want[7] = {held_bytes[11], held_bytes[10]};
      want[8] = {held_bytes[13], held_bytes[12]};
      want[9] = {8'h00, held_bytes[14]};
      frame_results.push_back(want);
   endtask

   // Feed the byte stream; advance the tracker on each accepted word.
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata);
            bytes_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= byte_feed.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Take result words, compare field by field with the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      telemetry_fields_type got;
      telemetry_fields_type want;
      logic bad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got[0] = {14'h0000, rsp_tuser};
            got[1] = {8'h00, rsp_tdata[7:0]};
            got[2] = {8'h00, rsp_tdata[15:8]};
            got[3] = {8'h00, rsp_tdata[23:16]};
            got[4] = rsp_tdata[39:24];
            got[5] = rsp_tdata[55:40];
            got[6] = rsp_tdata[71:56];
            got[7] = rsp_tdata[87:72];
            got[8] = rsp_tdata[103:88];
            got[9] = {8'h00, rsp_tdata[111:104]};
            if (frame_results.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: result word with nothing outstanding: status %0d",
                           $realtime, got[0]);
               error_count++;
            end else begin
               want = frame_results.pop_front();
               bad = 1'b0;
               for (int i = 0; i < FIELD_COUNT; i++) begin
                  if (got[i] !== want[i]) begin
                     if (error_count < 10)
                        $display("%0t: %s expected %h, got %h",
                                 $realtime, field_name[i], want[i], got[i]);
                     bad = 1'b1;
                  end
               end
               if (bad)
                  error_count++;
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long back-pressure stretch: hold rsp_tready low so the verdict queue fills
   // and the parser has to stall its input.
   initial begin : rsp_holdoff
      wait (hold_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic push_byte(input logic [7:0] b);
      byte_feed.push_back(b);
      bytes_queued++;
   endtask

   // Queue bytes that can never open a frame while the parser is hunting.
   task automatic push_noise(input int count);
      logic [7:0] b;
      repeat (count) begin
         do b = 8'($urandom_range(255)); while (b == sync_setting);
         push_byte(b);
      end
   endtask

   // Build one frame under the current settings, spoil it as asked and queue it.
   task automatic send_frame(input frame_kind_type kind, input fill_type fill);
      logic [7:0]  f [FRAME_LENGTH];
      logic [15:0] crc;
      int k;
      int bitn;
      int cut;
      f[0] = sync_setting;
      for (int i = 1; i <= TAG_BYTES; i++)
         f[i] = tag_setting[8*(i-1) +: 8];
      for (int i = TAG_FIRST + TAG_BYTES; i < FRAME_LENGTH - 2; i++) begin
         case (fill)
            FILL_ZERO: f[i] = 8'h00;
            FILL_ONES: f[i] = 8'hFF;
            FILL_SYNC: f[i] = sync_setting;
            default:   f[i] = 8'($urandom_range(255));
         endcase
      end
      // Spoil the tag before the checksum so a tag fault alone keeps a good CRC.
      if (kind == FK_TAG_BAD || kind == FK_BOTH_BAD) begin
         k = $urandom_range(TAG_FIRST + TAG_BYTES - 1, TAG_FIRST);
         bitn = $urandom_range(7);
         f[k][bitn] = ~f[k][bitn];
      end
      crc = CRC_START;
      for (int i = 0; i < FRAME_LENGTH - 2; i++)
         crc = crc16_step(crc, f[i]);
      f[FRAME_LENGTH-2] = crc[7:0];
      f[FRAME_LENGTH-1] = crc[15:8];
      if (kind == FK_CRC_BAD || kind == FK_BOTH_BAD) begin
         k = $urandom_range(FRAME_LENGTH - 1, FRAME_LENGTH - 2);
         bitn = $urandom_range(7);
         f[k][bitn] = ~f[k][bitn];
      end
      // A short frame is cut anywhere; the next bytes then complete it.
      cut = (kind == FK_SHORT) ? $urandom_range(FRAME_LENGTH - 1, 1) : FRAME_LENGTH;
      for (int i = 0; i < cut; i++)
         push_byte(f[i]);
   endtask

   // Hold the sender until every queued byte is taken, every result has come and
   // no frame is left half-open, then let the pipeline settle.
   task automatic drain_parser();
      forever begin
         do @(posedge clock);
         while (bytes_taken != bytes_queued || frame_results.size() != 0);
         if (!frame_open)
            break;
         // Close the open frame with filler so the parser is back to hunting.
         for (int i = byte_pos; i < FRAME_LENGTH; i++)
            push_byte(8'($urandom_range(255)));
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SYNC_BYTE)
         sync_setting = value[7:0];
      else
         tag_setting = value;
   endtask

   // Random frames: mostly well-formed, with spoilt and cut frames and idle noise.
   task automatic send_random_frames(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 60)      send_frame(FK_GOOD, FILL_RANDOM);
         else if (pick < 72) send_frame(FK_TAG_BAD, FILL_RANDOM);
         else if (pick < 84) send_frame(FK_CRC_BAD, FILL_RANDOM);
         else if (pick < 90) send_frame(FK_BOTH_BAD, FILL_RANDOM);
         else                send_frame(FK_SHORT, FILL_RANDOM);
         if ($urandom_range(2) == 0)
            push_noise($urandom_range(3, 1));
      end
   endtask

   initial begin : stimulus
      logic [7:0]  next_sync;
      logic [31:0] next_tag;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Phase 0: reset settings, sender idles lightly, receiver heavily.
      send_idle_pct = 24;
      recv_idle_pct = 85;
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h7F);
      // Bad checksum straight after reset: held fields must still read zero.
      send_frame(FK_CRC_BAD, FILL_RANDOM);
      send_frame(FK_GOOD, FILL_ONES);
      send_frame(FK_TAG_BAD, FILL_ZERO);
      send_frame(FK_BOTH_BAD, FILL_RANDOM);
      // Sync value throughout the payload: stored as data, no resync.
      send_frame(FK_GOOD, FILL_SYNC);
      send_frame(FK_GOOD, FILL_ZERO);
      send_random_frames(9);
      drain_parser();

      for (int p = 1; p < 6; p++) begin
         case (p)
            1: begin next_sync = 8'h00; next_tag = 32'h0000_0000; end
            2: begin next_sync = 8'hFF; next_tag = 32'hFFFF_FFFF; end
            5: begin next_sync = SYNC_RESET; next_tag = TAG_RESET; end
            default: begin
               next_sync = 8'($urandom_range(255));
               next_tag = $urandom();
            end
         endcase
         write_reg(CSR_SYNC_BYTE, {24'h000000, next_sync});
         write_reg(CSR_FRAME_TAG, next_tag);
         // Swap the idling around half-way, then run flat out.
         if (p < 2) begin
            send_idle_pct = 24;
            recv_idle_pct = 85;
         end else if (p < 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_random_frames(5);
         if (p == 4)
            hold_armed = 1'b1;
         drain_parser();
      end

      if (error_count == 0 && frame_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #(2_000_000);
      $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/etfp_pkg.sv
hw/rtl/etfp_front.sv
hw/rtl/etfp_queue.sv
hw/rtl/etfp_back.sv
hw/rtl/esc_telemetry_frame_parser.sv
bench/esc_telemetry_frame_parser_test.sv
